// ----- rtl/upc_pkg.sv -----
// Package for the URL percent codec: character constants, the decode
// pending-state type, the queued job type and character helper functions.
// No dependencies.
`default_nettype none

package upc_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_TILDE   = 8'h7E;

    // Decode-side pending state.
    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_PCT,
        PEND_HIGH
    } pend_state_t;

    // One classified input: up to three result bytes, sent in order b0, b1, b2.
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] cnt;
        logic       last;
    } job_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h41) && (c <= 8'h46))
            || ((c >= 8'h61) && (c <= 8'h66));
    endfunction

    // Value of a hex digit character; only meaningful where is_hex holds.
    function automatic logic [3:0] nib_of(input logic [7:0] c);
        logic [7:0] v;
        if (is_digit(c))
            v = c - 8'h30;
        else if (c >= 8'h61)
            v = c - 8'h57;
        else
            v = c - 8'h37;
        return v[3:0];
    endfunction

    function automatic logic is_unreserved(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A))
            || ((c >= 8'h61) && (c <= 8'h7A))
            || (c == CH_DASH) || (c == CH_UNDER) || (c == CH_DOT) || (c == CH_TILDE);
    endfunction

    // Upper-case hex digit character for a nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] c;
        unique case (n)
            4'h0: c = 8'h30;
            4'h1: c = 8'h31;
            4'h2: c = 8'h32;
            4'h3: c = 8'h33;
            4'h4: c = 8'h34;
            4'h5: c = 8'h35;
            4'h6: c = 8'h36;
            4'h7: c = 8'h37;
            4'h8: c = 8'h38;
            4'h9: c = 8'h39;
            4'hA: c = 8'h41;
            4'hB: c = 8'h42;
            4'hC: c = 8'h43;
            4'hD: c = 8'h44;
            4'hE: c = 8'h45;
            default: c = 8'h46;
        endcase
        return c;
    endfunction

    // A plus sign decodes to a space; everything else is literal.
    function automatic logic [7:0] plus_map(input logic [7:0] c);
        return (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/upc_front.sv -----
// Front end of the URL percent codec: holds the mode register and the decode
// pending state, and turns each accepted byte into a job of 0 to 3 result bytes.
// Depends on upc_pkg.
`default_nettype none

module upc_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_we,
    input  wire logic           cfg_wdata,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [7:0]     in_byte,
    input  wire logic           in_last,
    input  wire logic           q_full,
    output logic                push,
    output upc_pkg::job_t       push_job
);

    logic                 mode_reg;
    upc_pkg::pend_state_t state_reg, state_next;
    logic [7:0]           high_reg;
    logic                 accept;
    logic                 b_hex;
    logic                 b_pct_hold;
    upc_pkg::job_t        job;

    assign in_ready   = !q_full;
    assign accept     = in_valid && !q_full;
    assign b_hex      = upc_pkg::is_hex(in_byte);
    // A percent sign starts an escape unless the string ends on it.
    assign b_pct_hold = (in_byte == upc_pkg::CH_PERCENT) && !in_last;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg  <= 1'b0;
            state_reg <= upc_pkg::PEND_NONE;
        end else if (cfg_we) begin
            mode_reg  <= cfg_wdata;
            state_reg <= upc_pkg::PEND_NONE;
        end else if (accept && mode_reg) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            high_reg <= in_byte;
        end
    end

    // Next pending state for a decode-mode byte.
    always_comb begin
        state_next = upc_pkg::PEND_NONE;
        unique case (state_reg)
            upc_pkg::PEND_NONE: begin
                if (b_pct_hold)
                    state_next = upc_pkg::PEND_PCT;
            end
            upc_pkg::PEND_PCT: begin
                if (b_hex && !in_last)
                    state_next = upc_pkg::PEND_HIGH;
                else if (!b_hex && b_pct_hold)
                    state_next = upc_pkg::PEND_PCT;
            end
            upc_pkg::PEND_HIGH: begin
                if (!b_hex && b_pct_hold)
                    state_next = upc_pkg::PEND_PCT;
            end
            default: state_next = upc_pkg::PEND_NONE;
        endcase
    end

    // Result bytes for the accepted byte.
    always_comb begin
        job      = '0;
        job.last = in_last;
        if (!mode_reg) begin
            if (upc_pkg::is_unreserved(in_byte)) begin
                job.b0  = in_byte;
                job.cnt = 2'd1;
            end else begin
                job.b0  = upc_pkg::CH_PERCENT;
                job.b1  = upc_pkg::hex_char(in_byte[7:4]);
                job.b2  = upc_pkg::hex_char(in_byte[3:0]);
                job.cnt = 2'd3;
            end
        end else begin
            unique case (state_reg)
                upc_pkg::PEND_NONE: begin
                    if (!b_pct_hold) begin
                        job.b0  = upc_pkg::plus_map(in_byte);
                        job.cnt = 2'd1;
                    end
                end
                upc_pkg::PEND_PCT: begin
                    if (b_hex) begin
                        if (in_last) begin
                            job.b0  = upc_pkg::CH_PERCENT;
                            job.b1  = in_byte;
                            job.cnt = 2'd2;
                        end
                    end else if (b_pct_hold) begin
                        job.b0  = upc_pkg::CH_PERCENT;
                        job.cnt = 2'd1;
                    end else begin
                        job.b0  = upc_pkg::CH_PERCENT;
                        job.b1  = upc_pkg::plus_map(in_byte);
                        job.cnt = 2'd2;
                    end
                end
                upc_pkg::PEND_HIGH: begin
                    if (b_hex) begin
                        job.b0  = {upc_pkg::nib_of(high_reg), upc_pkg::nib_of(in_byte)};
                        job.cnt = 2'd1;
                    end else if (b_pct_hold) begin
                        job.b0  = upc_pkg::CH_PERCENT;
                        job.b1  = high_reg;
                        job.cnt = 2'd2;
                    end else begin
                        job.b0  = upc_pkg::CH_PERCENT;
                        job.b1  = high_reg;
                        job.b2  = upc_pkg::plus_map(in_byte);
                        job.cnt = 2'd3;
                    end
                end
                default: job.cnt = 2'd0;
            endcase
        end
    end

    assign push     = accept && (job.cnt != 2'd0);
    assign push_job = job;

endmodule

`default_nettype wire

// ----- rtl/upc_job_queue.sv -----
// Short job queue between the codec front end and back end.
// Depends on upc_pkg.
`default_nettype none

module upc_job_queue #(
    parameter int Depth = 2
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire upc_pkg::job_t  push_job,
    input  wire logic           pop,
    output upc_pkg::job_t       head_job,
    output logic                q_valid,
    output logic                q_full
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    upc_pkg::job_t   mem_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg;

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
    endfunction

    assign q_valid  = (count_reg != '0);
    assign q_full   = (count_reg == CntW'(Depth));
    assign head_job = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

// ----- rtl/upc_back.sv -----
// Back end of the URL percent codec: walks the bytes of the head job and
// drives the registered output channel. Depends on upc_pkg.
`default_nettype none

module upc_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    input  wire upc_pkg::job_t  head_job,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [7:0]          out_byte,
    output logic                out_last
);

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       load;
    logic       at_end;
    logic [7:0] sel_byte;

    assign load   = q_valid && (!out_valid_reg || out_ready);
    assign at_end = (idx_reg == 2'(head_job.cnt - 2'd1));
    assign pop    = load && at_end;

    always_comb begin
        unique case (idx_reg)
            2'd0:    sel_byte = head_job.b0;
            2'd1:    sel_byte = head_job.b1;
            default: sel_byte = head_job.b2;
        endcase
    end

    always_comb begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (load) begin
            idx_next       = at_end ? 2'd0 : idx_reg + 2'd1;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (load) begin
            out_byte_reg <= sel_byte;
            out_last_reg <= head_job.last && at_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

// ----- rtl/url_percent_codec.sv -----
// Top level of the URL percent codec: front end, job queue and back end.
// Depends on upc_pkg, upc_front, upc_job_queue and upc_back.
//
// Usage: bytes of a string enter on the input channel (in_valid/in_ready,
// in_byte, in_last) and converted bytes leave on the output channel
// (out_valid/out_ready, out_byte, out_last), one byte per transaction.
// The mode register is written with cfg_we/cfg_wdata (0 encodes, 1 decodes).
// The user must write it only while the block is idle; the block does not enforce
// this itself. A write also drops any held escape bytes. The front end takes one
// input transaction per cycle while the job queue has room and classifies it into
// zero to three result bytes; a percent sign or a high hex digit being held for an
// escape produces nothing yet. The back end sends one result byte per cycle from
// the head of the queue while the receiver is ready. The first result byte of an
// input passes through the job queue and then the output register before out_valid
// shows it, when the output side is free. Inputs that give one byte or none are
// taken one per cycle while the receiver keeps up; an input that gives several
// bytes holds the output channel for each of them in turn, so the sustained rate
// is set by the one-byte output register.
// When the receiver stalls, the output register holds its byte, the queue
// fills, and in_ready drops once QUEUE_DEPTH jobs wait.
// Reset clears the mode to encode, the pending escape state, the queue and
// the output valid flag.
`default_nettype none

module url_percent_codec #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_we,
    input  wire logic           cfg_wdata,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [7:0]     in_byte,
    input  wire logic           in_last,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [7:0]          out_byte,
    output logic                out_last
);

    logic          push;
    logic          pop;
    logic          q_valid;
    logic          q_full;
    upc_pkg::job_t push_job;
    upc_pkg::job_t head_job;

    // Classifies each input byte and tracks the decode escape state.
    upc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job)
    );

    // Decouples input acceptance from output stalls.
    upc_job_queue #(
        .Depth (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_valid  (q_valid),
        .q_full   (q_full)
    );

    // Serializes each job onto the output channel.
    upc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .head_job  (head_job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

endmodule

`default_nettype wire

// ----- rtl/upc_checker.sv -----
// Port-level checks for the URL percent codec, bound to the top level.
// No dependencies.
`default_nettype none

module upc_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_ready,
    input  wire logic       out_valid,
    input  wire logic       out_ready,
    input  wire logic [7:0] out_byte,
    input  wire logic       out_last
);

    // A stalled output byte holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
        else $error("output byte changed while stalled");

    // Nothing is shown on the output during reset.
    assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

    // With the output idle, the queue cannot be full.
    assert property (@(posedge clk) disable iff (!rst_n) !out_valid |-> in_ready)
        else $error("input stalled while output idle");

    // With the output idle, no output appears unless an input transaction is seen now or in its $past sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !(in_valid && in_ready) && $past(!(in_valid && in_ready))
        |=> !out_valid)
        else $error("output appeared without input");

endmodule

bind url_percent_codec upc_checker u_upc_checker (.*);

`default_nettype wire

// ----- verif/url_percent_codec_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for url_percent_codec: directed and random byte strings in
// both modes, with random gaps on input and output. Depends on upc_pkg and the RTL.
module url_percent_codec_tb;

    // One transaction on the output channel as the predictor expects it.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_beat_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_wdata;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       in_last;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;
    logic       out_last;

    url_percent_codec uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    // Predictor copy of the mode register and of the escape being held in decode mode.
    logic                 mode_dec;
    upc_pkg::pend_state_t esc_state;
    logic [7:0]           esc_high;

    // Converted bytes still owed by the block, oldest first, and the bytes of one step.
    out_beat_t   expected_beats[$];
    logic [7:0]  step_bytes[$];

    int errors;
    int rx_hold;
    // While calm is set neither side idles, so the block runs at full rate.
    bit calm;

    always #6 clk = ~clk;

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Value of a hex digit of either case, or -1 for any other byte.
    function automatic int hex_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return c - "0";
        if (c >= "a" && c <= "f")
            return c - "a" + 10;
        if (c >= "A" && c <= "F")
            return c - "A" + 10;
        return -1;
    endfunction

    // Bytes that the encoder passes through untouched.
    function automatic bit url_safe(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z")
            || c == upc_pkg::CH_DASH || c == upc_pkg::CH_UNDER
            || c == upc_pkg::CH_DOT || c == upc_pkg::CH_TILDE;
    endfunction

    function automatic logic [7:0] upper_hex(input logic [3:0] n);
        return (n < 4'd10) ? 8'h30 + n : 8'h37 + n;
    endfunction

    // Appends one converted byte to the bytes of the current step.
    function automatic void add_step_byte(input logic [7:0] b);
        step_bytes = {step_bytes, b};
    endfunction

    // Decode a byte with no escape held: a percent sign opens an escape unless the
    // string ends here, a plus sign becomes a space, anything else is literal.
    function automatic void decode_plain(input logic [7:0] b, input logic l);
        if (b == upc_pkg::CH_PERCENT && !l)
            esc_state = upc_pkg::PEND_PCT;
        else
            add_step_byte((b == upc_pkg::CH_PLUS) ? upc_pkg::CH_SPACE : b);
    endfunction

    // Work out the converted bytes of one accepted input transaction and queue them.
    function automatic void predict_conversion(input logic [7:0] b, input logic l);
        upc_pkg::pend_state_t held;
        logic [7:0]  high;
        int          hi_v;
        int          lo_v;
        out_beat_t   beat;
        step_bytes.delete();
        if (!mode_dec) begin
            if (url_safe(b))
            begin
                add_step_byte(b);
            end
            else
            begin
                add_step_byte(upc_pkg::CH_PERCENT);
                add_step_byte(upper_hex(b[7:4]));
                add_step_byte(upper_hex(b[3:0]));
            end
        end
        else
        begin
            held      = esc_state;
            high      = esc_high;
            esc_state = upc_pkg::PEND_NONE;
            esc_high  = 8'h00;
            hi_v      = hex_value(high);
            lo_v      = hex_value(b);
            case (held)
                upc_pkg::PEND_PCT:
                begin
                    if (lo_v >= 0 && !l)
                    begin
                        esc_state = upc_pkg::PEND_HIGH;
                        esc_high  = b;
                    end
                    else if (lo_v >= 0)
                    begin
                        // Truncated escape at the end of the string goes out literally.
                        add_step_byte(upc_pkg::CH_PERCENT);
                        add_step_byte(b);
                    end
                    else
                    begin
                        // Broken escape: emit the percent sign and look at this byte again.
                        add_step_byte(upc_pkg::CH_PERCENT);
                        decode_plain(b, l);
                    end
                end
                upc_pkg::PEND_HIGH:
                begin
                    if (hi_v >= 0 && lo_v >= 0)
                    begin
                        add_step_byte({hi_v[3:0], lo_v[3:0]});
                    end
                    else
                    begin
                        add_step_byte(upc_pkg::CH_PERCENT);
                        add_step_byte((high == upc_pkg::CH_PLUS) ? upc_pkg::CH_SPACE : high);
                        decode_plain(b, l);
                    end
                end
                default:
                begin
                    decode_plain(b, l);
                end
            endcase
        end
        foreach (step_bytes[i])
        begin
            beat.data = step_bytes[i];
            beat.last = l && (i == step_bytes.size() - 1);
            expected_beats = {expected_beats, beat};
        end
    endfunction

    // Receiver: out_ready changes at the falling edge, with stalls of random length.
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            out_ready <= 1'b0;
            rx_hold   <= rx_hold - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            rx_hold   <= pick_gap();
        end
    end

    // Every output transaction is compared with the oldest expected byte.
    always @(posedge clk)
    begin : check_output
        out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_beats.size() == 0)
            begin
                $display("%0t: unexpected output transaction, byte %02h last %0b",
                         $time, out_byte, out_last);
                errors++;
            end
            else
            begin
                want = expected_beats.pop_front();
                if (out_byte !== want.data)
                begin
                    $display("%0t: out_byte expected %02h, actual %02h",
                             $time, want.data, out_byte);
                    errors++;
                end
                if (out_last !== want.last)
                begin
                    $display("%0t: out_last expected %0b, actual %0b (byte %02h)",
                             $time, want.last, out_last, out_byte);
                    errors++;
                end
            end
        end
    end

    // Send one byte. in_valid stays high from one transaction to the next unless a
    // gap is drawn, and the prediction is made at the edge that accepts the byte.
    task automatic send_byte(input logic [7:0] b, input logic l);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_byte  <= b;
        in_last  <= l;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        predict_conversion(b, l);
    endtask

    // Send a whole string with the end mark on its final byte.
    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    task automatic hold_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Mode writes happen only with the block idle: all expected bytes out, then a further
    // wait so that a held escape byte has surely settled in the front end.
    task automatic set_mode(input logic v);
        hold_input();
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        mode_dec  = v;
        esc_state = upc_pkg::PEND_NONE;
        esc_high  = 8'h00;
    endtask

    // Encode mode straight out of reset: the byte extremes, the unreserved set and
    // bytes that must be escaped.
    task automatic test_encode_directed();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_text("Az09-_.~%");
    endtask

    // Decode mode: lower-case escape, a broken escape whose second byte opens a new
    // one, plus sign, and escapes cut short by the end of the string.
    task automatic test_decode_directed();
        send_text("%4a");
        send_text("%%4G+");
        send_text("%4");
        send_text("%");
    endtask

    // A mode write drops the percent sign being held.
    task automatic test_mode_write_drop();
        send_byte(upc_pkg::CH_PERCENT, 1'b0);
        set_mode(1'b1);
        send_text("41");
    endtask

    task automatic test_random_encode(input int n_items);
        for (int i = 0; i < n_items; i++)
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    endtask

    function automatic logic [7:0] rand_hex_char();
        logic [3:0] n;
        n = 4'($urandom_range(0, 15));
        if (n < 4'd10)
            return 8'h30 + n;
        return ($urandom_range(0, 1) == 1) ? 8'h37 + n : 8'h57 + n;
    endfunction

    // Mostly well-formed escapes with random digits of either case, mixed with plain
    // text, plus signs, random noise and broken or truncated escapes.
    task automatic test_random_decode(input int n_items);
        logic [7:0] text[$];
        int         sent;
        int         target;
        int         pick;
        sent = 0;
        while (sent < n_items)
        begin
            text.delete();
            target = $urandom_range(1, 10);
            while (text.size() < target)
            begin
                pick = $urandom_range(0, 9);
                case (pick)
                    0, 1, 2, 3:
                    begin
                        text = {text, upc_pkg::CH_PERCENT, rand_hex_char(), rand_hex_char()};
                    end
                    4:
                    begin
                        text = {text, upc_pkg::CH_PLUS};
                    end
                    5, 6:
                    begin
                        text = {text, 8'($urandom_range(8'h21, 8'h7E))};
                    end
                    7:
                    begin
                        text = {text, 8'($urandom_range(0, 255))};
                    end
                    8:
                    begin
                        text = {text, upc_pkg::CH_PERCENT, 8'($urandom_range(0, 255))};
                    end
                    default:
                    begin
                        text = {text, upc_pkg::CH_PERCENT, rand_hex_char(),
                                8'($urandom_range(0, 255))};
                    end
                endcase
            end
            // Now and then the string ends inside an escape.
            if ($urandom_range(0, 5) == 0)
            begin
                text = {text, upc_pkg::CH_PERCENT};
                if ($urandom_range(0, 1) == 1)
                    text = {text, rand_hex_char()};
            end
            foreach (text[i])
                send_byte(text[i], i == text.size() - 1);
            sent += text.size();
        end
    endtask

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        in_valid  = 1'b0;
        in_byte   = 8'h00;
        in_last   = 1'b0;
        out_ready = 1'b0;
        rx_hold   = 0;
        errors    = 0;
        calm      = 1'b0;
        mode_dec  = 1'b0;
        esc_state = upc_pkg::PEND_NONE;
        esc_high  = 8'h00;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_encode_directed();
        set_mode(1'b1);
        test_decode_directed();
        test_mode_write_drop();
        set_mode(1'b0);
        test_random_encode(45);
        set_mode(1'b1);
        test_random_decode(70);
        // A stretch at full rate on both sides.
        calm = 1'b1;
        test_random_decode(15);
        calm = 1'b0;
        set_mode(1'b0);
        test_random_encode(15);

        hold_input();
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("url_percent_codec_tb: done, clean");
        else
            $display("url_percent_codec_tb: done, errors");
        $finish;
    end

    // The slowest correct run is a few hundred microseconds; this is far beyond it.
    initial
    begin
        #3_000_000;
        $display("url_percent_codec_tb: done, errors");
        $finish;
    end

endmodule
